// ===== rtl/srag_pkg.sv =====
package srag_pkg;

  localparam logic [63:0] RankMask = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] FileMask = 64'h0101_0101_0101_0101;

  typedef struct packed {
    logic [63:0] occupancy;
    logic [5:0]  square;
  } srag_query_t;

  typedef struct packed {
    logic [63:0] straight_attacks;
    logic [63:0] diagonal_attacks;
  } srag_attacks_t;

  typedef struct packed {
    logic [63:0] rank;
    logic [63:0] file;
    logic [63:0] diag;
    logic [63:0] anti;
  } srag_masks_t;

endpackage

// ===== rtl/srag_masks.sv =====
module srag_masks (
  input  logic [5:0]           square,
  output srag_pkg::srag_masks_t masks
);
  import srag_pkg::*;

  function automatic logic [63:0] diag_line(logic [5:0] sq, logic anti);
    logic [63:0] m;
    logic [5:0]  b;
    logic [3:0]  lhs;
    logic [3:0]  rhs;
    m = '0;
    for (int i = 0; i < 64; i++) begin
      b = 6'(i);
      if (anti) begin
        lhs = {1'b0, b[2:0]} + {1'b0, b[5:3]};
        rhs = {1'b0, sq[2:0]} + {1'b0, sq[5:3]};
      end else begin
        // f_i - r_i == f - r, rearranged to stay unsigned
        lhs = {1'b0, b[2:0]} + {1'b0, sq[5:3]};
        rhs = {1'b0, sq[2:0]} + {1'b0, b[5:3]};
      end
      m[i] = (lhs == rhs);
    end
    return m;
  endfunction

  always_comb begin
    masks.rank = RankMask << {square[5:3], 3'b000};
    masks.file = FileMask << square[2:0];
    masks.diag = diag_line(square, 1'b0);
    masks.anti = diag_line(square, 1'b1);
  end

endmodule

// ===== rtl/srag_line.sv =====
module srag_line (
  input  logic [63:0] occupancy,
  input  logic [63:0] line_mask,
  input  logic [5:0]  square,
  output logic [63:0] attacks
);
  import srag_pkg::*;

  function automatic logic [63:0] bit_rev(logic [63:0] a);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = a[63 - i];
    end
    return r;
  endfunction

  logic [63:0] occ_line;
  logic [63:0] twice_up;
  logic [63:0] twice_down;
  logic [63:0] fwd;
  logic [63:0] bwd;

  // shifts past bit 63 drop out, giving zero at the board corners
  always_comb begin
    occ_line   = occupancy & line_mask;
    twice_up   = 64'd2 << square;
    twice_down = 64'd2 << (~square);
    fwd        = occ_line - twice_up;
    bwd        = bit_rev(bit_rev(occ_line) - twice_down);
    attacks    = (fwd ^ bwd) & line_mask;
  end

endmodule

// ===== rtl/sliding_ray_attack_generator_core.sv =====
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------
// query    | start / busy       | occupancy[63:0], square[5:0]
// result   | done (1-cycle)     | straight_attacks, diagonal_attacks
//
// One transaction per cycle; each result passes the input and result registers.
// Path: input register -> line masks, 64-bit subtracts -> result register.
// busy is high only during reset; rst clears the pipeline valids.
// The receiver cannot stall; done pulses for exactly one cycle.
module sliding_ray_attack_generator_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  srag_pkg::srag_query_t   query,
  output logic                   done,
  output srag_pkg::srag_attacks_t result
);
  import srag_pkg::*;

  logic          valid_q;
  srag_query_t   query_q;
  srag_masks_t   masks;
  logic [63:0]   rank_att;
  logic [63:0]   file_att;
  logic [63:0]   diag_att;
  logic [63:0]   anti_att;
  srag_attacks_t result_next;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_q <= start;
      done    <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    query_q <= query;
    result  <= result_next;
  end

  srag_masks u_masks (
    .square (query_q.square),
    .masks  (masks)
  );

  srag_line u_rank (
    .occupancy (query_q.occupancy),
    .line_mask (masks.rank),
    .square    (query_q.square),
    .attacks   (rank_att)
  );

  srag_line u_file (
    .occupancy (query_q.occupancy),
    .line_mask (masks.file),
    .square    (query_q.square),
    .attacks   (file_att)
  );

  srag_line u_diag (
    .occupancy (query_q.occupancy),
    .line_mask (masks.diag),
    .square    (query_q.square),
    .attacks   (diag_att)
  );

  srag_line u_anti (
    .occupancy (query_q.occupancy),
    .line_mask (masks.anti),
    .square    (query_q.square),
    .attacks   (anti_att)
  );

  always_comb begin
    result_next.straight_attacks = rank_att | file_att;
    result_next.diagonal_attacks = diag_att | anti_att;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction did not complete in two cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##2 !done)
    else $error("result strobe without a transaction");

  a_disjoint: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.straight_attacks & result.diagonal_attacks) == 64'd0))
    else $error("straight and diagonal attacks overlap");

  a_straight_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.straight_attacks != 64'd0))
    else $error("straight attacks empty");

endmodule
